// ===== src/assert_macros.svh =====
// Assertion macros used by the port checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Implication checked also during reset
`define ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

// ===== src/fadd_pkg.sv =====
// Shared constants and status codes of the binary32 adder
`timescale 1ns / 1ps
`default_nettype none
package fadd_pkg;
	localparam logic [7:0] EXP_ALL_ONES = 8'hFF;
	localparam logic [7:0] EXP_ZERO = 8'h00;
	localparam int EXP_MAX_NORMAL = 254;
	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_OVERFLOW = 3'd1;
	localparam logic [2:0] ST_UNDERFLOW = 3'd2;
	localparam logic [2:0] ST_NAN = 3'd3;
	localparam logic [2:0] ST_INF = 3'd4;
	localparam logic [2:0] ST_DENORM = 3'd5;
	localparam logic [2:0] ST_ZERO = 3'd6;
endpackage
`default_nettype wire

// ===== src/fadd_core.sv =====
// Combinational binary32 add: align, add, normalize, classify
`timescale 1ns / 1ps
`default_nettype none
module fadd_core import fadd_pkg::*; (
	input  wire logic [31:0] a,
	input  wire logic [31:0] b,
	output logic      [31:0] word,
	output logic      [2:0]  st
);
	logic [7:0] ea, eb;
	logic [22:0] fa, fb;
	logic za, zb;
	logic [8:0] d;
	logic a_big;
	logic [4:0] sh;
	logic [23:0] mbig, msml, msh;
	logic [24:0] mal;
	logic sbig, ssml;
	logic [25:0] mag;
	logic [25:0] nrm;
	logic [4:0] lz;
	logic found;
	logic [9:0] ex;
	logic sgn;

	assign ea = a[30:23];
	assign eb = b[30:23];
	assign fa = a[22:0];
	assign fb = b[22:0];
	assign za = (a[30:0] == 31'd0);
	assign zb = (b[30:0] == 31'd0);

	always_comb begin
		word = 32'd0;
		st = ST_OK;
		a_big = (ea >= eb);
		d = a_big ? {1'b0, ea - eb} : {1'b0, eb - ea};
		sh = d[4:0];
		mbig = a_big ? {1'b1, fa} : {1'b1, fb};
		msml = a_big ? {1'b1, fb} : {1'b1, fa};
		sbig = a_big ? a[31] : b[31];
		ssml = a_big ? b[31] : a[31];
		// round the aligned operand with the first bit shifted out
		msh = msml >> sh;
		if (sh == 5'd0)
			mal = {1'b0, msml};
		else
			mal = {1'b0, msh} + {24'd0, msml[sh - 5'd1]};
		// signed-magnitude add
		sgn = sbig;
		if (sbig == ssml)
			mag = {2'b0, mbig} + {1'b0, mal};
		else if ({1'b0, mbig} >= mal)
			mag = {2'b0, mbig} - {1'b0, mal};
		else begin
			mag = {1'b0, mal} - {2'b0, mbig};
			sgn = ssml;
		end
		// equal magnitudes with opposite signs: the zero result gets a positive sign
		if (sbig != ssml && {1'b0, mbig} == mal)
			sgn = 1'b0;
		// normalize
		ex = {2'b0, a_big ? ea : eb};
		nrm = mag;
		lz = 5'd0;
		found = 1'b0;
		for (int i = 23; i >= 0; i--) begin
			if (!found && mag[i]) begin
				found = 1'b1;
				lz = 5'(23 - i);
			end
		end
		if (mag[24]) begin
			nrm = (mag >> 1) + {25'd0, mag[0]};
			ex = ex + 10'd1;
		end else begin
			nrm = mag << lz;
		end
		// classify in priority order
		priority if ((ea == EXP_ALL_ONES && fa != 0) || (eb == EXP_ALL_ONES && fb != 0))
			st = ST_NAN;
		else if (ea == EXP_ALL_ONES || eb == EXP_ALL_ONES)
			st = ST_INF;
		else if ((ea == EXP_ZERO && fa != 0) || (eb == EXP_ZERO && fb != 0))
			st = ST_DENORM;
		else if (za && zb)
			st = ST_ZERO;
		else if (za)
			word = b;
		else if (zb)
			word = a;
		else if (d > 9'd24)
			word = a_big ? a : b;
		else if (mag == 26'd0)
			word = 32'd0;
		else if (mag[24] && ex > 10'(EXP_MAX_NORMAL))
			st = ST_OVERFLOW;
		else if (!mag[24] && {5'd0, lz} > ex)
			st = ST_UNDERFLOW;
		else if (mag[24])
			word = {sgn, ex[7:0], nrm[22:0]};
		else
			word = {sgn, 8'(ex - {5'd0, lz}), nrm[22:0]};
	end
endmodule
`default_nettype wire

// ===== src/binary32_float_adder.sv =====
// Top level of the binary32 adder: input and result registers around the add core
//  channel | ports                          | handshake
//  in      | operand_a, operand_b           | start && !busy
//  out     | sum_word, status               | done strobe, one cycle
// One addition per cycle; the input transfer sets v_s1 and loads the input register,
// then v_s1 sets v_s2 (done) and loads sum_word and status from the add core.
// The latency is set by the input register and the result register around
// one combinational add path. busy is always low; the receiver cannot stall.
// Reset clears the valid flags only.
`timescale 1ns / 1ps
`default_nettype none
module binary32_float_adder import fadd_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [31:0] operand_a,
	input  wire logic [31:0] operand_b,
	output logic             done,
	output logic      [31:0] sum_word,
	output logic      [2:0]  status
);
	logic [31:0] a_s1, b_s1, w;
	logic [2:0] st;
	logic v_s1, v_s2;

	assign busy = 1'b0;

	fadd_core u_core (.a(a_s1), .b(b_s1), .word(w), .st(st));

	// advance valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
			v_s2 <= v_s1;
		end
	end

	// hold payload
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			a_s1 <= operand_a;
			b_s1 <= operand_b;
		end
		if (v_s1) begin
			sum_word <= w;
			status <= st;
		end
	end

	assign done = v_s2;
endmodule
`default_nettype wire

// ===== src/fadd_checker.sv =====
// Port checker for the binary32 adder and its bind
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module fadd_checker import fadd_pkg::*; (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        start,
	input wire logic        busy,
	input wire logic        done,
	input wire logic [31:0] sum_word,
	input wire logic [2:0]  status
);
	`ASSERT_CLK(a_lat, clk, arst_n, start && !busy |-> ##2 done, "missing result")
	`ASSERT_CLK(a_nospur, clk, arst_n, done |-> $past(start && !busy, 2), "spurious result")
	`ASSERT_CLK(a_range, clk, arst_n, done |-> status <= ST_ZERO, "bad status")
	`ASSERT_CLK(a_zero, clk, arst_n, done && status != ST_OK |-> sum_word == 32'd0, "sum not zero")
	`ASSERT_ALWAYS(a_busy, clk, !busy, "busy raised")
endmodule
bind binary32_float_adder fadd_checker u_chk (.*);
`default_nettype wire

// ===== test/testbench.sv =====
// Self-checking testbench of the binary32 adder: directed and random operand pairs
`timescale 1ns / 1ps
`default_nettype none

class sum_scoreboard;
	logic [31:0] exp_word [$];
	logic [2:0] exp_status [$];
	int errors;

	// Compute the expected sum of two normal, nonzero operands
	function automatic logic [31:0] add_normal(logic [31:0] a, logic [31:0] b,
			output logic [2:0] st);
		int ea, eb, d, e, sh;
		longint va, vb, s;
		logic [31:0] ma, mb, mag;
		logic sgn;
		st = fadd_pkg::ST_OK;
		ea = int'(a[30:23]);
		eb = int'(b[30:23]);
		ma = {9'd1, a[22:0]};
		mb = {9'd1, b[22:0]};
		d = ea - eb;
		if (d > 24) return a;
		if (d < -24) return b;
		e = (d >= 0) ? ea : eb;
		if (d > 0) begin
			sh = d;
			mb = (mb >> sh) + ((mb >> (sh - 1)) & 1);
		end else if (d < 0) begin
			sh = -d;
			ma = (ma >> sh) + ((ma >> (sh - 1)) & 1);
		end
		va = a[31] ? -longint'(ma) : longint'(ma);
		vb = b[31] ? -longint'(mb) : longint'(mb);
		s = va + vb;
		sgn = s < 0;
		mag = 32'(sgn ? -s : s);
		if (mag == 0) return 32'd0;
		while (mag[24]) begin
			mag = (mag >> 1) + mag[0];
			e++;
			if (e > fadd_pkg::EXP_MAX_NORMAL) begin
				st = fadd_pkg::ST_OVERFLOW;
				return 32'd0;
			end
		end
		while (!mag[23]) begin
			mag = mag << 1;
			e--;
			if (e < 0) begin
				st = fadd_pkg::ST_UNDERFLOW;
				return 32'd0;
			end
		end
		return {sgn, e[7:0], mag[22:0]};
	endfunction

	// Note an accepted operand pair and queue its expected result
	function void note_operands(logic [31:0] a, logic [31:0] b);
		logic [2:0] st;
		logic [31:0] w;
		w = 32'd0;
		st = fadd_pkg::ST_OK;
		if ((a[30:23] == fadd_pkg::EXP_ALL_ONES && a[22:0] != 0) ||
				(b[30:23] == fadd_pkg::EXP_ALL_ONES && b[22:0] != 0))
			st = fadd_pkg::ST_NAN;
		else if (a[30:23] == fadd_pkg::EXP_ALL_ONES || b[30:23] == fadd_pkg::EXP_ALL_ONES)
			st = fadd_pkg::ST_INF;
		else if ((a[30:23] == fadd_pkg::EXP_ZERO && a[22:0] != 0) ||
				(b[30:23] == fadd_pkg::EXP_ZERO && b[22:0] != 0))
			st = fadd_pkg::ST_DENORM;
		else if (a[30:0] == 0 && b[30:0] == 0)
			st = fadd_pkg::ST_ZERO;
		else if (a[30:0] == 0)
			w = b;
		else if (b[30:0] == 0)
			w = a;
		else begin
			w = add_normal(a, b, st);
			if (st != fadd_pkg::ST_OK) w = 32'd0;
		end
		exp_word.push_back(w);
		exp_status.push_back(st);
	endfunction

	task report(string what);
		$display("mismatch at %0t: %s", $time, what);
		errors++;
	endtask

	// Compare a result with the oldest expectation
	task check_sum(logic [31:0] w, logic [2:0] st);
		logic [31:0] ew;
		logic [2:0] es;
		if (exp_word.size() == 0) begin
			report($sformatf("unexpected result %h/%0d", w, st));
			return;
		end
		ew = exp_word.pop_front();
		es = exp_status.pop_front();
		if (w !== ew) report($sformatf("sum_word %h, expected %h", w, ew));
		if (st !== es) report($sformatf("status %0d, expected %0d", st, es));
	endtask
endclass

module testbench;
	import fadd_pkg::*;

	logic clk, arst_n, start, busy, done;
	logic [31:0] operand_a, operand_b, sum_word;
	logic [2:0] status;
	sum_scoreboard board;
	bit calm;

	binary32_float_adder dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.operand_a(operand_a), .operand_b(operand_b),
		.done(done), .sum_word(sum_word), .status(status)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Check every result strobe
	always @(posedge clk) begin
		if (arst_n && done) board.check_sum(sum_word, status);
	end

	// Build a random operand, mostly normal, sometimes special
	function automatic logic [31:0] rand_operand(logic [7:0] near);
		logic [31:0] v;
		int k;
		v = $urandom;
		k = $urandom_range(0, 99);
		if (k < 55) v[30:23] = 8'(32'(near) + $urandom_range(0, 6) - 32'd3);
		else if (k < 62) v[30:0] = 31'd0;
		else if (k < 66) v[30:23] = EXP_ALL_ONES;
		else if (k < 70) v[30:23] = EXP_ZERO;
		else if (k < 74) v[22:0] = 23'd0;
		if (v[30:23] == EXP_ZERO && k >= 55 && k < 70 && $urandom_range(0, 1)) v[22:0] = 0;
		return v;
	endfunction

	// Present one operand pair and wait for its transfer
	task send_pair(logic [31:0] a, logic [31:0] b);
		while (!calm && $urandom_range(0, 99) < 18) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		operand_a <= a;
		operand_b <= b;
		@(posedge clk);
		while (busy) @(posedge clk);
		board.note_operands(a, b);
		@(negedge clk);
	endtask

	initial begin
		logic [7:0] e;
		board = new();
		arst_n = 1'b0;
		start = 1'b0;
		operand_a = 32'd0;
		operand_b = 32'd0;
		calm = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: extremes and every special case
		send_pair(32'h3F80_0000, 32'h4000_0000);
		send_pair(32'h3F80_0000, 32'hBF80_0000);
		send_pair(32'h7F7F_FFFF, 32'h7F7F_FFFF);
		send_pair(32'h0080_0000, 32'h8080_0001);
		send_pair(32'h0080_0000, 32'h8000_0000);
		send_pair(32'h7FC0_0000, 32'h7F80_0000);
		send_pair(32'hFF80_0000, 32'h3F80_0000);
		send_pair(32'h7F80_0001, 32'hFFFF_FFFF);
		send_pair(32'h0000_0001, 32'h3F80_0000);
		send_pair(32'h4000_0000, 32'h807F_FFFF);
		send_pair(32'h0000_0000, 32'h8000_0000);
		send_pair(32'h8000_0000, 32'hC2F6_0000);
		send_pair(32'h4B80_0000, 32'h0000_0000);
		send_pair(32'h4C80_0000, 32'h3F80_0000);
		send_pair(32'h3F80_0000, 32'h4C00_0000);
		send_pair(32'h4C00_0000, 32'h3F80_0000);
		send_pair(32'h3FFF_FFFF, 32'h3400_0000);
		send_pair(32'h3F80_0001, 32'hBF80_0000);
		send_pair(32'h0100_0000, 32'h8100_0001);
		send_pair(32'hFFFF_FFFF, 32'h0000_0000);
		send_pair(32'hFF7F_FFFF, 32'hFF00_0000);

		// Random: a calm stretch in the middle
		for (int i = 0; i < 500; i++) begin
			calm = (i >= 200 && i < 300);
			e = 8'($urandom_range(0, 255));
			send_pair(rand_operand(e), rand_operand(e));
		end
		start <= 1'b0;

		while (board.exp_word.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (board.errors == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("testbench failed");
		$finish;
	end
endmodule
